// ===== design/cosine_similarity_vectors_assert.svh =====
// Assertion macros shared by the design files.
`ifndef COSINE_SIMILARITY_VECTORS_ASSERT_SVH
`define COSINE_SIMILARITY_VECTORS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/csv_pkg.sv =====
package csv_pkg;

  // Width of the element ports.
  localparam int IN_W = 16;
  // Elements are zero padded to this width before the low bits are taken.
  localparam int PAD_W = 32;
  // Width of the similarity result.
  localparam int SIM_W = 16;
  // Operands of the closing multiplications are split into two limbs.
  localparam int LIMB_W = 32;
  localparam int OP_W = 2 * LIMB_W;
  localparam int MACC_W = 2 * OP_W;
  // Entries of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  // The rounded ratio is searched one bit a step, top bit first.
  localparam int K_W = 16;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_CHK,
    ST_MUL,
    ST_SRCH_A,
    ST_SRCH_B,
    ST_OUT
  } csv_state_e;

endpackage

// ===== design/csv_queue.sv =====
module csv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`include "cosine_similarity_vectors_assert.svh"
  `CSV_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, rd_i, !empty_o)
  `CSV_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(DEPTH))

endmodule

// ===== design/csv_front.sv =====
module csv_front #(
  parameter int MAX_LEN = 1024,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     full_i,
  input  logic [csv_pkg::IN_W-1:0] elem_a_i,
  input  logic [csv_pkg::IN_W-1:0] elem_b_i,
  input  logic                     last_i,
  output logic                     busy_o,
  output logic                     push_o,
  output logic [3+3*2*ELEM_WIDTH-1:0] push_data_o
);

  localparam int PRD_W = 2 * ELEM_WIDTH;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [csv_pkg::PAD_W-1:0] a_pad, b_pad;
  logic signed [ELEM_WIDTH-1:0] a_s, b_s;
  logic signed [PRD_W-1:0] dot_p, sqa_p, sqb_p;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d;
  logic full_len;
  logic take;

  // Only the low ELEM_WIDTH bits of each element carry the value.
  assign a_pad = csv_pkg::PAD_W'(elem_a_i);
  assign b_pad = csv_pkg::PAD_W'(elem_b_i);
  assign a_s   = $signed(a_pad[ELEM_WIDTH-1:0]);
  assign b_s   = $signed(b_pad[ELEM_WIDTH-1:0]);

  // Products of the pair, written into the queue.
  assign dot_p = a_s * b_s;
  assign sqa_p = a_s * a_s;
  assign sqb_p = b_s * b_s;

  assign busy_o   = full_i;
  assign take     = start_i && !full_i;
  assign push_o   = take;
  assign full_len = (cnt_q >= CNT_W'(MAX_LEN));

  // Beat: last, overflow seen, accumulate, then the three products.
  assign push_data_o = {last_i, ovf_q | full_len, !full_len,
                        dot_p, sqa_p, sqb_p};

  // Pair count and overflow tracking, cleared when the vectors close.
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (take) begin
      if (last_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (full_len) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

`include "cosine_similarity_vectors_assert.svh"
  `CSV_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(MAX_LEN))
  `CSV_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_o, !full_i)

endmodule

// ===== design/csv_back.sv =====
module csv_back #(
  parameter int ELEM_WIDTH = 16,
  parameter int ACC_W = 42
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  logic [3+3*2*ELEM_WIDTH-1:0] rd_data_i,
  output logic                      rd_o,
  output logic                      done_o,
  output logic [csv_pkg::SIM_W-1:0] similarity_o,
  output logic                      zero_norm_o,
  output logic                      too_long_o
);

  localparam int PRD_W = 2 * ELEM_WIDTH;
  localparam int ENT_W = 3 + 3 * PRD_W;
  localparam int PW = 2 * ACC_W;
  localparam int SW = PW + 37;
  localparam int KB_W = $clog2(csv_pkg::K_W);

  csv_pkg::csv_state_e state_q, state_d;

  // Beat fields.
  logic e_last, e_ovf, e_acc;
  logic signed [PRD_W-1:0] e_dot;
  logic [PRD_W-1:0] e_sqa, e_sqb;

  logic signed [ACC_W-1:0] dot_q, dot_d;
  logic [ACC_W-1:0] na_q, na_d, nb_q, nb_d;
  logic ovf_q, ovf_d, neg_q, neg_d;
  logic [ACC_W-1:0] mag_w;
  logic [csv_pkg::OP_W-1:0] mag_q, mag_d;

  // Limb multiplier sequencer.
  logic phase_q, phase_d;
  logic [1:0] pp_q, pp_d;
  logic [csv_pkg::OP_W-1:0] op_x, op_y;
  logic [csv_pkg::LIMB_W-1:0] limb_x, limb_y;
  logic [csv_pkg::OP_W-1:0] pp;
  logic [1:0] shamt;
  logic [csv_pkg::MACC_W-1:0] pp_sh, macc_q, macc_d;
  logic [PW-1:0] p_q, p_d;

  // Bitwise search of the rounded ratio.
  logic signed [SW-1:0] r_q, r_d, s_q, s_d, u_q, u_d, v_q, v_d;
  logic signed [SW-1:0] sum1_q, sum1_d, ustep_q, ustep_d, trial;
  logic [KB_W-1:0] bit_q, bit_d;
  logic [csv_pkg::K_W-1:0] k_q, k_d;

  logic done_d, zn_d, tl_d;
  logic [csv_pkg::SIM_W-1:0] sim_d;

  assign e_last = rd_data_i[ENT_W-1];
  assign e_ovf  = rd_data_i[ENT_W-2];
  assign e_acc  = rd_data_i[ENT_W-3];
  assign e_dot  = $signed(rd_data_i[3*PRD_W-1:2*PRD_W]);
  assign e_sqa  = rd_data_i[2*PRD_W-1:PRD_W];
  assign e_sqb  = rd_data_i[PRD_W-1:0];

  assign rd_o = (state_q == csv_pkg::ST_ACC) && !empty_i;

  // Magnitude of the dot product.
  assign mag_w = dot_q[ACC_W-1] ? $unsigned(-dot_q) : $unsigned(dot_q);

  // One 32 by 32 partial product a cycle.
  assign op_x   = phase_q ? mag_q : csv_pkg::OP_W'(na_q);
  assign op_y   = phase_q ? mag_q : csv_pkg::OP_W'(nb_q);
  assign limb_x = pp_q[1] ? op_x[csv_pkg::OP_W-1:csv_pkg::LIMB_W]
                          : op_x[csv_pkg::LIMB_W-1:0];
  assign limb_y = pp_q[0] ? op_y[csv_pkg::OP_W-1:csv_pkg::LIMB_W]
                          : op_y[csv_pkg::LIMB_W-1:0];
  assign pp     = limb_x * limb_y;
  assign shamt  = {1'b0, pp_q[1]} + {1'b0, pp_q[0]};
  assign pp_sh  = csv_pkg::MACC_W'(pp) << {shamt, 5'b0};

  assign trial = sum1_q + v_q;

  // Sequencer: accumulate, check, multiply, search, report.
  always_comb begin
    state_d = state_q;
    dot_d   = dot_q;
    na_d    = na_q;
    nb_d    = nb_q;
    ovf_d   = ovf_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    phase_d = phase_q;
    pp_d    = pp_q;
    macc_d  = macc_q;
    p_d     = p_q;
    r_d     = r_q;
    s_d     = s_q;
    u_d     = u_q;
    v_d     = v_q;
    sum1_d  = sum1_q;
    ustep_d = ustep_q;
    bit_d   = bit_q;
    k_d     = k_q;
    done_d  = 1'b0;
    zn_d    = 1'b0;
    tl_d    = 1'b0;
    sim_d   = '0;
    unique case (state_q)
      csv_pkg::ST_ACC: begin
        if (!empty_i) begin
          if (e_acc) begin
            dot_d = dot_q + ACC_W'(e_dot);
            na_d  = na_q + ACC_W'(e_sqa);
            nb_d  = nb_q + ACC_W'(e_sqb);
          end
          if (e_last) begin
            ovf_d   = e_ovf;
            state_d = csv_pkg::ST_CHK;
          end
        end
      end
      csv_pkg::ST_CHK: begin
        if (ovf_q || na_q == '0 || nb_q == '0) begin
          done_d  = 1'b1;
          tl_d    = ovf_q;
          zn_d    = !ovf_q;
          dot_d   = '0;
          na_d    = '0;
          nb_d    = '0;
          state_d = csv_pkg::ST_ACC;
        end else begin
          neg_d   = dot_q[ACC_W-1];
          mag_d   = csv_pkg::OP_W'(mag_w);
          phase_d = 1'b0;
          pp_d    = '0;
          state_d = csv_pkg::ST_MUL;
        end
      end
      csv_pkg::ST_MUL: begin
        macc_d = ((pp_q == '0) ? '0 : macc_q) + pp_sh;
        pp_d   = pp_q + 1'b1;
        if (pp_q == 2'd3) begin
          if (!phase_q) begin
            p_d     = macc_d[PW-1:0];
            phase_d = 1'b1;
          end else begin
            // Squared dot product scaled by 2^32, then the search start.
            r_d     = $signed(SW'({macc_d[PW-1:0], 32'b0}));
            s_d     = $signed(SW'(p_q));
            v_d     = $signed(SW'({p_q, 32'b0}));
            u_d     = -$signed(SW'({p_q, 17'b0}));
            bit_d   = KB_W'(csv_pkg::K_W - 1);
            k_d     = '0;
            state_d = csv_pkg::ST_SRCH_A;
          end
        end
      end
      csv_pkg::ST_SRCH_A: begin
        sum1_d  = s_q + u_q;
        ustep_d = u_q + (v_q <<< 1);
        state_d = csv_pkg::ST_SRCH_B;
      end
      csv_pkg::ST_SRCH_B: begin
        // Keep the bit when (2k-1)^2 * P stays within 2^32 * dot^2.
        if (trial <= r_q) begin
          s_d        = trial;
          u_d        = ustep_q >>> 1;
          k_d[bit_q] = 1'b1;
        end else begin
          u_d = u_q >>> 1;
        end
        v_d = v_q >>> 2;
        if (bit_q == '0) begin
          state_d = csv_pkg::ST_OUT;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = csv_pkg::ST_SRCH_A;
        end
      end
      csv_pkg::ST_OUT: begin
        done_d = 1'b1;
        if (k_q[csv_pkg::K_W-1]) begin
          // Magnitude reached 1.0.
          sim_d = neg_q ? {1'b1, {(csv_pkg::SIM_W-1){1'b0}}}
                        : {1'b0, {(csv_pkg::SIM_W-1){1'b1}}};
        end else begin
          sim_d = neg_q ? -k_q : k_q;
        end
        dot_d   = '0;
        na_d    = '0;
        nb_d    = '0;
        state_d = csv_pkg::ST_ACC;
      end
      default: state_d = csv_pkg::ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= csv_pkg::ST_ACC;
      dot_q        <= '0;
      na_q         <= '0;
      nb_q         <= '0;
      ovf_q        <= 1'b0;
      phase_q      <= 1'b0;
      pp_q         <= '0;
      bit_q        <= '0;
      done_o       <= 1'b0;
      zero_norm_o  <= 1'b0;
      too_long_o   <= 1'b0;
      similarity_o <= '0;
    end else begin
      state_q      <= state_d;
      dot_q        <= dot_d;
      na_q         <= na_d;
      nb_q         <= nb_d;
      ovf_q        <= ovf_d;
      phase_q      <= phase_d;
      pp_q         <= pp_d;
      bit_q        <= bit_d;
      done_o       <= done_d;
      zero_norm_o  <= zn_d;
      too_long_o   <= tl_d;
      similarity_o <= sim_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    macc_q  <= macc_d;
    p_q     <= p_d;
    r_q     <= r_d;
    s_q     <= s_d;
    u_q     <= u_d;
    v_q     <= v_d;
    sum1_q  <= sum1_d;
    ustep_q <= ustep_d;
    k_q     <= k_d;
  end

`include "cosine_similarity_vectors_assert.svh"
  `CSV_ASSERT_IMP(a_flags_excl, clk_i, rst_ni, done_o, !(zero_norm_o && too_long_o))
  `CSV_ASSERT_IMP(a_flag_zero, clk_i, rst_ni, done_o && (zero_norm_o || too_long_o),
                  similarity_o == '0)
  `CSV_ASSERT_NXT(a_srch_pair, clk_i, rst_ni, state_q == csv_pkg::ST_SRCH_A,
                  state_q == csv_pkg::ST_SRCH_B)
  `CSV_ASSERT_IMP(a_pop_acc, clk_i, rst_ni, rd_o, state_q == csv_pkg::ST_ACC)

endmodule

// ===== design/cosine_similarity_vectors.sv =====
// Channel   Direction  Handshake          Beat
// pairs     in         start_i, busy_o    elem_a_i, elem_b_i, last_i
// results   out        done_o (strobe)    similarity_o, zero_norm_o, too_long_o
//
// One element pair is taken per cycle while busy_o is low; a four entry
// queue sits between the front (products, pair count) and the back (sums,
// closing ratio). Closing the vectors in the back takes 8 limb products on
// one 32x32 multiplier and a 16 bit search in states ST_SRCH_A and ST_SRCH_B.
// busy_o is high while the queue is full; the result is held one cycle only.
// Reset clears all control state at once; there is no clearing pass.
module cosine_similarity_vectors #(
  parameter int MAX_LEN = 1024,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [csv_pkg::IN_W-1:0]  elem_a_i,
  input  logic [csv_pkg::IN_W-1:0]  elem_b_i,
  input  logic                      last_i,
  output logic                      done_o,
  output logic [csv_pkg::SIM_W-1:0] similarity_o,
  output logic                      zero_norm_o,
  output logic                      too_long_o
);

  localparam int ACC_RAW = 2 * ELEM_WIDTH + $clog2(MAX_LEN);
  localparam int ACC_W = (ACC_RAW > 64) ? 64 : ACC_RAW;
  localparam int ENT_W = 3 + 3 * 2 * ELEM_WIDTH;

  logic push, pop, full, empty;
  logic [ENT_W-1:0] push_data, pop_data;

  // Front: accepts pairs and forms the products.
  csv_front #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .full_i      (full),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .last_i      (last_i),
    .busy_o      (busy_o),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue between front and back.
  csv_queue #(
    .WIDTH (ENT_W),
    .DEPTH (csv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (push_data),
    .rd_i      (pop),
    .rd_data_o (pop_data),
    .full_o    (full),
    .empty_o   (empty)
  );

  // Back: sums and the closing ratio.
  csv_back #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .ACC_W      (ACC_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .rd_data_i    (pop_data),
    .rd_o         (pop),
    .done_o       (done_o),
    .similarity_o (similarity_o),
    .zero_norm_o  (zero_norm_o),
    .too_long_o   (too_long_o)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_PAIRS = 1024;
  localparam int RANDOM_ITEMS = 830;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic        last;
  } pair_t;

  typedef struct packed {
    logic [15:0] sim;
    logic        zero_norm;
    logic        too_long;
  } cosine_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] elem_a_i = '0;
  logic [15:0] elem_b_i = '0;
  logic        last_i = 1'b0;
  logic        done_o;
  logic [15:0] similarity_o;
  logic        zero_norm_o;
  logic        too_long_o;

  pair_t   pending_pairs[$];
  cosine_t expected_cosines[$];

  // Running sums of the predictor, kept modulo 2^64; the block's sums are ACC_W bits wide.
  logic [63:0] dot_acc, norm_a_acc, norm_b_acc;
  int unsigned pairs_in_vector;
  logic        overflow_hit;

  int unsigned gap_left;
  bit          no_idle;
  int unsigned idle_cycles;
  int unsigned errors, vectors_seen, zero_seen, long_seen;

  cosine_similarity_vectors dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .elem_a_i, .elem_b_i, .last_i,
    .done_o, .similarity_o, .zero_norm_o, .too_long_o
  );

  always #5 clk_i = ~clk_i;

  // Rounded magnitude: largest k with (2k-1)^2 * na * nb <= 2^32 * dot^2.
  function automatic logic [15:0] cosine_of(logic [63:0] dot, logic [63:0] na,
                                            logic [63:0] nb);
    logic [191:0] prod, dsh, odd, lhs;
    logic [63:0]  mag;
    logic         neg;
    int unsigned  lo, hi, mid;
    neg = dot[63];
    mag = neg ? (~dot + 64'd1) : dot;
    prod = {128'd0, na} * {128'd0, nb};
    dsh = ({128'd0, mag} * {128'd0, mag}) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 192'(2 * mid - 1);
      lhs = odd * odd * prod;
      if (lhs <= dsh) lo = mid;
      else hi = mid - 1;
    end
    if (neg) return 16'(0 - lo);
    return (lo >= 32768) ? 16'd32767 : 16'(lo);
  endfunction

  // Accumulate one accepted beat and queue a result on the closing beat.
  task automatic predict_pair(pair_t p);
    logic [63:0] a, b;
    cosine_t     r;
    a = {{48{p.a[15]}}, p.a};
    b = {{48{p.b[15]}}, p.b};
    if (pairs_in_vector >= MAX_PAIRS) begin
      overflow_hit = 1'b1;
    end else begin
      dot_acc += a * b;
      norm_a_acc += a * a;
      norm_b_acc += b * b;
      pairs_in_vector++;
    end
    if (p.last) begin
      r = '0;
      if (overflow_hit) r.too_long = 1'b1;
      else if (norm_a_acc == 0 || norm_b_acc == 0) r.zero_norm = 1'b1;
      else r.sim = cosine_of(dot_acc, norm_a_acc, norm_b_acc);
      expected_cosines.push_back(r);
      dot_acc = '0;
      norm_a_acc = '0;
      norm_b_acc = '0;
      pairs_in_vector = 0;
      overflow_hit = 1'b0;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Driver: presents one beat at a time, holding it while busy_o is high.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      elem_a_i <= '0;
      elem_b_i <= '0;
      last_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (start_i && !busy_o) predict_pair('{elem_a_i, elem_b_i, last_i});
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          start_i <= 1'b0;
          gap_left--;
        end else if (pending_pairs.size() > 0) begin
          pair_t p;
          p = pending_pairs.pop_front();
          elem_a_i <= p.a;
          elem_b_i <= p.b;
          last_i <= p.last;
          start_i <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start_i <= 1'b0;
        end
      end
      if ($urandom_range(199) == 0) no_idle = !no_idle;
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o || (start_i && !busy_o)) idle_cycles = 0;
      else idle_cycles++;
      if (done_o) begin
        if (expected_cosines.size() == 0) begin
          $error("unexpected result: similarity %0d", $signed(similarity_o));
          errors++;
        end else begin
          cosine_t e;
          e = expected_cosines.pop_front();
          vectors_seen++;
          if (e.zero_norm) zero_seen++;
          if (e.too_long) long_seen++;
          if (similarity_o !== e.sim) begin
            $error("similarity: expected %0d, got %0d", $signed(e.sim),
                   $signed(similarity_o));
            errors++;
          end
          if (zero_norm_o !== e.zero_norm) begin
            $error("zero_norm: expected %0b, got %0b", e.zero_norm, zero_norm_o);
            errors++;
          end
          if (too_long_o !== e.too_long) begin
            $error("too_long: expected %0b, got %0b", e.too_long, too_long_o);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 expected_cosines.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [15:0] random_elem(int unsigned style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32)) - 16);
      default: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  // Queues one vector pair; shape 0 random, 1 b follows a, 2 b mirrors a,
  // 3 a all zero, 4 b all zero.
  task automatic queue_vector(int unsigned len, int unsigned shape);
    int unsigned style;
    logic [15:0] a, b;
    style = $urandom_range(2);
    for (int unsigned i = 0; i < len; i++) begin
      a = random_elem(style);
      b = random_elem(style);
      case (shape)
        1: b = a + 16'($signed($urandom_range(4)) - 2);
        2: b = -a;
        3: a = '0;
        4: b = '0;
        default: ;
      endcase
      pending_pairs.push_back('{a, b, i == len - 1});
    end
  endtask

  initial begin
    int unsigned queued, len, roll;
    dot_acc = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    pairs_in_vector = 0;
    overflow_hit = 1'b0;
    errors = 0;
    vectors_seen = 0;
    zero_seen = 0;
    long_seen = 0;
    idle_cycles = 0;
    no_idle = 1'b0;

    // Directed: single pair vectors at the extremes, parallel, opposite,
    // orthogonal and all-zero vectors.
    pending_pairs.push_back('{16'h7fff, 16'h7fff, 1'b1});
    pending_pairs.push_back('{16'h8000, 16'h8000, 1'b1});
    pending_pairs.push_back('{16'h8000, 16'h7fff, 1'b1});
    pending_pairs.push_back('{16'h0001, 16'hffff, 1'b1});
    pending_pairs.push_back('{16'h0001, 16'h0000, 1'b0});
    pending_pairs.push_back('{16'h0000, 16'h0001, 1'b1});
    pending_pairs.push_back('{16'h0000, 16'h1234, 1'b1});
    pending_pairs.push_back('{16'h5555, 16'h0000, 1'b1});
    pending_pairs.push_back('{16'h0000, 16'h0000, 1'b1});
    pending_pairs.push_back('{16'h7fff, 16'h8000, 1'b0});
    pending_pairs.push_back('{16'h8000, 16'h7fff, 1'b1});
    queue_vector(3, 2);
    queue_vector(4, 1);
    queue_vector(2, 0);

    // Random vectors, mostly short with a few long ones.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      roll = $urandom_range(99);
      len = (roll < 90) ? $urandom_range(12, 1) : $urandom_range(80, 13);
      roll = $urandom_range(99);
      queue_vector(len, roll < 50 ? 0 : roll < 70 ? 1 : roll < 85 ? 2 :
                        roll < 93 ? 3 : 4);
      queued += len;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs.size() > 0 || start_i || expected_cosines.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d vectors closed: %0d with a zero norm, %0d over length",
             vectors_seen, zero_seen, long_seen);
    if (errors == 0 && expected_cosines.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
